### hdl/fnspw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnspw_pkg
// Types, constants and word builders for the synthesizer program word core.
// ----------------------------------------------------------------------------
package fnspw_pkg;

    // Command opcodes
    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_FREQ  = 2'd1;
    localparam logic [1:0] OP_POWER = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLED = 2'd0;
    localparam logic [1:0] CFG_MIN     = 2'd1;
    localparam logic [1:0] CFG_MAX     = 2'd2;

    // Field widths
    localparam int unsigned FREQ_W  = 13;
    localparam int unsigned FRAC1_W = 24;
    localparam int unsigned PFD_W   = 7;
    localparam int unsigned QUO_W   = 8;

    // Reset values of the limit registers
    localparam logic [FREQ_W-1:0] MIN_FREQ_RST = 13'd54;
    localparam logic [FREQ_W-1:0] MAX_FREQ_RST = 13'd6800;

    // Phase detector frequencies in MHz
    localparam logic [PFD_W-1:0] PFD_HALF = 7'd50;
    localparam logic [PFD_W-1:0] PFD_FULL = 7'd100;

    // Reciprocal of 25 scaled by 2^17; exact for dividends below 8192.
    localparam logic [FREQ_W-1:0] RECIP_25 = 13'd5243;

    // Whole part of 2^24 / PFD; the leftover is 16 for both PFDs.
    localparam logic [FRAC1_W-1:0] FRAC_Q_HALF = 24'd335544;
    localparam logic [FRAC1_W-1:0] FRAC_Q_FULL = 24'd167772;

    // Fixed register words
    localparam logic [31:0] REG10_WORD     = 32'h00C0_3EBA;
    localparam logic [31:0] REG6_BASE      = 32'h750D_0076;
    localparam logic [31:0] REG4_CNT_RESET = 32'h3400_DD94;
    localparam logic [31:0] REG4_HALF_PFD  = 32'h3600_DD84;
    localparam logic [31:0] REG4_FULL_PFD  = 32'h3400_DD84;
    localparam logic [31:0] PD_BIT         = 32'h0000_0040;
    localparam logic [31:0] AUTOCAL_BIT    = 32'h0020_0000;
    localparam logic [FREQ_W-1:0] N_HIGH_BAND = 13'd75;

    // Index of the final word of each run, and of the word followed by a pause
    localparam logic [4:0] INIT_LAST_IDX = 5'd16;
    localparam logic [4:0] FREQ_LAST_IDX = 5'd11;
    localparam logic [4:0] PAUSE_IDX     = 5'd6;

    // Kind of run being emitted
    typedef enum logic [1:0] {
        KIND_INIT,
        KIND_FREQ,
        KIND_POWER,
        KIND_ERROR
    } kind_t;

    // Start-up table
    function automatic logic [31:0] init_word(input logic [4:0] idx);
        logic [31:0] w;
        unique case (idx)
            5'd0:    w = 32'hFFFF_041C;
            5'd1:    w = 32'h0061_300B;
            5'd2:    w = 32'h00C0_3EBA;
            5'd3:    w = 32'h2A29_FCC9;
            5'd4:    w = 32'h102D_0428;
            5'd5:    w = 32'h1200_0067;
            5'd6:    w = 32'h75AD_0076;
            5'd7:    w = 32'h0080_0025;
            5'd8:    w = 32'h3600_DD84;
            5'd9:    w = 32'h0000_0003;
            5'd10:   w = 32'h0050_0322;
            5'd11:   w = 32'h0666_6661;
            5'd12:   w = 32'h0020_0660;
            5'd13:   w = 32'h3400_DD84;
            5'd14:   w = 32'h0050_0642;
            5'd15:   w = 32'h0333_3331;
            5'd16:   w = 32'h0000_0330;
            default: w = 32'h0000_0000;
        endcase
        return w;
    endfunction

    // Register 2: second fractional word and modulus
    function automatic logic [31:0] reg2_word(input logic [PFD_W-1:0] frac2,
                                              input logic [PFD_W-1:0] pfd);
        return {7'd0, frac2, 7'd0, pfd, 4'h2};
    endfunction

    // Register 1: main fractional word
    function automatic logic [31:0] reg1_word(input logic [FRAC1_W-1:0] frac1);
        return {4'd0, frac1, 4'h1};
    endfunction

    // Register 0: integer divide value with band select
    function automatic logic [31:0] reg0_word(input logic [FREQ_W-1:0] n);
        logic hb;
        hb = (n >= N_HIGH_BAND);
        return {11'd0, hb, 3'd0, n, 4'd0};
    endfunction

endpackage

### hdl/frac_n_synth_program_words_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frac_n_synth_program_words_core
// Turns synthesizer commands into runs of 32-bit register programming words.
// ----------------------------------------------------------------------------
//
// Channel   | Ports                              | Contents
// ----------+------------------------------------+-----------------------------
// command   | s_tvalid s_tready s_tdata s_tuser  | opcode, freq_mhz, shutdown
// words     | m_tvalid m_tready m_tdata m_tlast  | reg_word, last,
//           | m_tuser                            | pause_after, error
// config    | cfg_valid cfg_ready cfg_index      | enabled, min_freq_mhz,
//           | cfg_data                           | max_freq_mhz
//
// A set-frequency command first passes through one shared divide-by-PFD unit
// (a multiply by the reciprocal of 25, then a remainder step, done for the
// integer part and for the fraction, once for a 50 MHz and once for a
// 100 MHz PFD), then emits 12 words at one per cycle. Init emits 17 words;
// power and rejected commands emit one. Output stalls hold the word register
// and pause the run. A new command is taken once the previous run is fully
// loaded into the output register. Reset clears the limits to 54 and
// 6800 MHz and the enable to zero; the config port is always ready.
module frac_n_synth_program_words_core
    import fnspw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Command transaction
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [12:0] freq_mhz, [13] shutdown, [15:14] zero
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    // Word transaction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] reg_word
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [0] pause_after, [1] error
    // Configuration write transaction
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Divide sequence for one PFD
    typedef enum logic [1:0] {
        STEP_QN,
        STEP_RN,
        STEP_QF,
        STEP_RF
    } step_t;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;

    logic              enabled_reg, enabled_next;
    logic [FREQ_W-1:0] min_reg, min_next;
    logic [FREQ_W-1:0] max_reg, max_next;

    logic              pd_reg, pd_next;
    logic [2:0]        bits_reg, bits_next;
    logic [FREQ_W-1:0] k_reg, k_next;
    logic [4:0]        idx_reg, idx_next;

    // Shared divide unit
    step_t             step_reg, step_next;
    logic [FREQ_W-1:0] dx_reg, dx_next;
    logic [QUO_W-1:0]  q_reg, q_next;
    logic [PFD_W-1:0]  r_reg, r_next;
    logic              pass_reg, pass_next;

    // Divider results per PFD
    logic [FREQ_W-1:0]  na_reg, na_next, nb_reg, nb_next;
    logic [FRAC1_W-1:0] f1a_reg, f1a_next, f1b_reg, f1b_next;
    logic [PFD_W-1:0]   f2a_reg, f2a_next, f2b_reg, f2b_next;

    // Output register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic        m_tlast_reg, m_tlast_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    logic [1:0]        in_op;
    logic [FREQ_W-1:0] in_freq;
    logic [2:0]        in_bits;
    logic              in_bad;

    logic [PFD_W-1:0]    pfd;
    logic [FRAC1_W-1:0]  fq;
    logic [2*FREQ_W-1:0] prod;
    logic [8:0]          q25;
    logic [QUO_W-1:0]    q_w;
    logic [14:0]         qp;
    logic [FREQ_W-1:0]   rem_w;
    logic [FRAC1_W-1:0]  f1_w;

    logic [31:0] word_w;
    logic        last_w;
    logic        pause_w;
    logic        err_w;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tuser   = m_tuser_reg;

    assign in_op   = s_tuser;
    assign in_freq = s_tdata[12:0];

    // Output divider selection as a power of two
    always_comb
    begin
        priority if (in_freq >= 13'd3400) in_bits = 3'd0;
        else if (in_freq >= 13'd1700)     in_bits = 3'd1;
        else if (in_freq >= 13'd850)      in_bits = 3'd2;
        else if (in_freq >= 13'd425)      in_bits = 3'd3;
        else if (in_freq >= 13'd213)      in_bits = 3'd4;
        else if (in_freq >= 13'd107)      in_bits = 3'd5;
        else                              in_bits = 3'd6;
    end

    // Rejection: disabled, unused opcode, or frequency outside the limits
    assign in_bad = !enabled_reg
                 || (in_op != OP_INIT && in_op != OP_FREQ && in_op != OP_POWER)
                 || (in_op == OP_FREQ && (in_freq < min_reg || in_freq > max_reg));

    // Quotient by the PFD: divide by 25, then by 2 or 4
    assign pfd   = pass_reg ? PFD_FULL : PFD_HALF;
    assign fq    = pass_reg ? FRAC_Q_FULL : FRAC_Q_HALF;
    assign prod  = dx_reg * RECIP_25;
    assign q25   = prod[2*FREQ_W-1:17];
    assign q_w   = pass_reg ? {1'b0, q25[8:2]} : q25[8:1];

    // Remainder from the registered quotient, and the main fraction
    assign qp    = {7'd0, q_reg} * {8'd0, pfd};
    assign rem_w = dx_reg - qp[FREQ_W-1:0];
    assign f1_w  = ({17'd0, r_reg} * fq) + {16'd0, q_reg};

    // Word selection for the current run position
    always_comb
    begin
        word_w  = 32'd0;
        last_w  = 1'b1;
        pause_w = 1'b0;
        err_w   = 1'b0;
        unique case (kind_reg)
            KIND_INIT:
            begin
                word_w  = init_word(idx_reg);
                last_w  = (idx_reg == INIT_LAST_IDX);
                pause_w = 1'b1;
            end
            KIND_POWER:
            begin
                word_w = REG4_FULL_PFD | (pd_reg ? PD_BIT : 32'd0);
            end
            KIND_ERROR:
            begin
                err_w = 1'b1;
            end
            KIND_FREQ:
            begin
                last_w  = (idx_reg == FREQ_LAST_IDX);
                pause_w = (idx_reg == PAUSE_IDX);
                unique case (idx_reg)
                    5'd0:    word_w = REG10_WORD;
                    5'd1:    word_w = REG6_BASE | {8'd0, bits_reg, 21'd0};
                    5'd2:    word_w = REG4_CNT_RESET;
                    5'd3:    word_w = reg2_word(f2a_reg, PFD_HALF);
                    5'd4:    word_w = reg1_word(f1a_reg);
                    5'd5:    word_w = reg0_word(na_reg);
                    5'd6:    word_w = REG4_HALF_PFD;
                    5'd7:    word_w = reg0_word(na_reg) | AUTOCAL_BIT;
                    5'd8:    word_w = REG4_FULL_PFD;
                    5'd9:    word_w = reg2_word(f2b_reg, PFD_FULL);
                    5'd10:   word_w = reg1_word(f1b_reg);
                    5'd11:   word_w = reg0_word(nb_reg);
                    default: word_w = 32'd0;
                endcase
            end
        endcase
    end

    // Next-state logic
    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        enabled_next  = enabled_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        pd_next       = pd_reg;
        bits_next     = bits_reg;
        k_next        = k_reg;
        idx_next      = idx_reg;
        step_next     = step_reg;
        dx_next       = dx_reg;
        q_next        = q_reg;
        r_next        = r_reg;
        pass_next     = pass_reg;
        na_next       = na_reg;
        nb_next       = nb_reg;
        f1a_next      = f1a_reg;
        f1b_next      = f1b_reg;
        f2a_next      = f2a_reg;
        f2b_next      = f2b_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;

        // Configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ENABLED: enabled_next = cfg_data[0];
                CFG_MIN:     min_next     = cfg_data;
                CFG_MAX:     max_next     = cfg_data;
                default:     ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    pd_next   = s_tdata[13];
                    bits_next = in_bits;
                    idx_next  = 5'd0;
                    priority if (in_bad)
                    begin
                        kind_next  = KIND_ERROR;
                        state_next = ST_EMIT;
                    end
                    else if (in_op == OP_INIT)
                    begin
                        kind_next  = KIND_INIT;
                        state_next = ST_EMIT;
                    end
                    else if (in_op == OP_POWER)
                    begin
                        kind_next  = KIND_POWER;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        kind_next  = KIND_FREQ;
                        k_next     = FREQ_W'(in_freq << in_bits);
                        dx_next    = FREQ_W'(in_freq << in_bits);
                        step_next  = STEP_QN;
                        pass_next  = 1'b0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                unique case (step_reg)
                    // Integer part N of K / PFD
                    STEP_QN:
                    begin
                        q_next    = q_w;
                        step_next = STEP_RN;
                    end
                    // Remainder r, then divide 16 * r for the fraction
                    STEP_RN:
                    begin
                        r_next    = rem_w[PFD_W-1:0];
                        dx_next   = {2'd0, rem_w[PFD_W-1:0], 4'd0};
                        step_next = STEP_QF;
                        if (!pass_reg)
                        begin
                            na_next = {5'd0, q_reg};
                        end
                        else
                        begin
                            nb_next = {5'd0, q_reg};
                        end
                    end
                    STEP_QF:
                    begin
                        q_next    = q_w;
                        step_next = STEP_RF;
                    end
                    // frac1 = r * (2^24 div PFD) + 16r div PFD, frac2 = 16r mod PFD
                    STEP_RF:
                    begin
                        step_next = STEP_QN;
                        dx_next   = k_reg;
                        if (!pass_reg)
                        begin
                            f1a_next  = f1_w;
                            f2a_next  = rem_w[PFD_W-1:0];
                            pass_next = 1'b1;
                        end
                        else
                        begin
                            f1b_next   = f1_w;
                            f2b_next   = rem_w[PFD_W-1:0];
                            state_next = ST_EMIT;
                        end
                    end
                endcase
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = word_w;
                    m_tlast_next  = last_w;
                    m_tuser_next  = {err_w, pause_w};
                    idx_next      = idx_reg + 5'd1;
                    if (last_w)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            kind_reg     <= KIND_ERROR;
            enabled_reg  <= 1'b0;
            min_reg      <= MIN_FREQ_RST;
            max_reg      <= MAX_FREQ_RST;
            pd_reg       <= 1'b0;
            bits_reg     <= '0;
            k_reg        <= '0;
            idx_reg      <= '0;
            step_reg     <= STEP_QN;
            dx_reg       <= '0;
            q_reg        <= '0;
            r_reg        <= '0;
            pass_reg     <= 1'b0;
            na_reg       <= '0;
            nb_reg       <= '0;
            f1a_reg      <= '0;
            f1b_reg      <= '0;
            f2a_reg      <= '0;
            f2b_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
            m_tuser_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            enabled_reg  <= enabled_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            pd_reg       <= pd_next;
            bits_reg     <= bits_next;
            k_reg        <= k_next;
            idx_reg      <= idx_next;
            step_reg     <= step_next;
            dx_reg       <= dx_next;
            q_reg        <= q_next;
            r_reg        <= r_next;
            pass_reg     <= pass_next;
            na_reg       <= na_next;
            nb_reg       <= nb_next;
            f1a_reg      <= f1a_next;
            f1b_reg      <= f1b_next;
            f2a_reg      <= f2a_next;
            f2b_reg      <= f2b_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tlast_reg  <= m_tlast_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

endmodule
